// ----- design/mer_pkg.sv -----
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, codes and controller/datapath interface types for the
// midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

   // coordinate and radius width of the input fields
   localparam int COORD_BITS = 10;

   // derived widths
   localparam int PIX_W      = 12;                      // output pixel coordinate
   localparam int STEP_W     = COORD_BITS + 1;          // signed x / y offsets
   localparam int SQ_W       = 2 * COORD_BITS;          // a^2, b^2
   localparam int MUL_W      = 2 * COORD_BITS + 4;      // multiplier operand
   localparam int PROD_W     = 2 * MUL_W;               // multiplier product
   localparam int DEC_W      = 4 * COORD_BITS + 8;      // decision value
   localparam int SLOPE_W    = 3 * COORD_BITS + 4;      // fx, fy
   localparam int PIX_SUM_W  = (COORD_BITS + 2 > PIX_W) ? COORD_BITS + 2 : PIX_W;

   // request function codes
   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_ADVANCE = 1'b1;

   // index of the fourth word of an item
   localparam logic [1:0] LAST_POINT = 2'd3;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_SQ_A,
      CS_SQ_B,
      CS_MUL_AB,
      CS_INIT,
      CS_INIT_DIV,
      CS_SW_XX,
      CS_SW_YY,
      CS_SW_B2T,
      CS_SW_A2T,
      CS_SW_A2B2,
      CS_SW_SUB,
      CS_SW_DIV,
      CS_STEP,
      CS_EMIT
   } ctrl_state_type;

   // multiplier operand pairs
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_AA,      // a * a
      MUL_BB,      // b * b
      MUL_A2B,     // a^2 * b
      MUL_XX,      // (2x+1)^2
      MUL_YY,      // (y-1)^2
      MUL_B2T,     // b^2 * tmp
      MUL_A2T,     // a^2 * tmp
      MUL_A2B2     // a^2 * b^2
   } mul_sel_type;

   // accumulator operations
   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,    // acc = prod
      ACC_ADD4,    // acc += 4*prod
      ACC_SUB4R,   // acc += 2 - 4*prod
      ACC_INIT     // acc = 4b^2 - 4*prod + a^2 + 2
   } acc_op_type;

   typedef struct packed {
      logic        load_params;
      mul_sel_type mul_sel;
      logic        a2_load;
      logic        b2_load;
      logic        tmp_load;
      acc_op_type  acc_op;
      logic        init_run;
      logic        dec_load;
      logic        set_r2;
      logic        step;
      logic        emit_load;
      logic [1:0]  point_idx;
   } mer_cmd_type;

   typedef struct packed {
      logic active;
      logic need_switch;
      logic out_free;
   } mer_status_type;

endpackage

// ----- design/mer_ctrl.sv -----
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer: start setup, region switch multiply chain and word emission.
// ----------------------------------------------------------------------------
module mer_ctrl
   import mer_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_func,
   output logic           req_ready,
   input  mer_status_type status,
   output mer_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = '0;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_START) begin
                  state_in = CS_SQ_A;
               end else if (status.active) begin
                  state_in = status.need_switch ? CS_SW_XX : CS_EMIT;
               end
            end
         end
         CS_SQ_A:     state_in = CS_SQ_B;
         CS_SQ_B:     state_in = CS_MUL_AB;
         CS_MUL_AB:   state_in = CS_INIT;
         CS_INIT:     state_in = CS_INIT_DIV;
         CS_INIT_DIV: state_in = CS_EMIT;
         CS_SW_XX:    state_in = CS_SW_YY;
         CS_SW_YY:    state_in = CS_SW_B2T;
         CS_SW_B2T:   state_in = CS_SW_A2T;
         CS_SW_A2T:   state_in = CS_SW_A2B2;
         CS_SW_A2B2:  state_in = CS_SW_SUB;
         CS_SW_SUB:   state_in = CS_SW_DIV;
         CS_SW_DIV:   state_in = CS_STEP;
         CS_STEP:     state_in = CS_EMIT;
         CS_EMIT: begin
            idx_in = idx_ff;
            if (status.out_free) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == LAST_POINT) begin
                  state_in = CS_IDLE;
               end
            end
         end
         default:     state_in = CS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready       = 1'b0;
      cmd.load_params = 1'b0;
      cmd.mul_sel     = MUL_NONE;
      cmd.a2_load     = 1'b0;
      cmd.b2_load     = 1'b0;
      cmd.tmp_load    = 1'b0;
      cmd.acc_op      = ACC_HOLD;
      cmd.init_run    = 1'b0;
      cmd.dec_load    = 1'b0;
      cmd.set_r2      = 1'b0;
      cmd.step        = 1'b0;
      cmd.emit_load   = 1'b0;
      cmd.point_idx   = idx_ff;
      case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == FUNC_START) begin
                  cmd.load_params = 1'b1;
               end else if (status.active && !status.need_switch) begin
                  cmd.step = 1'b1;
               end
            end
         end
         CS_SQ_A:   cmd.mul_sel = MUL_AA;
         CS_SQ_B: begin
            cmd.a2_load = 1'b1;
            cmd.mul_sel = MUL_BB;
         end
         CS_MUL_AB: begin
            cmd.b2_load = 1'b1;
            cmd.mul_sel = MUL_A2B;
         end
         CS_INIT: begin
            cmd.acc_op   = ACC_INIT;
            cmd.init_run = 1'b1;
         end
         CS_INIT_DIV: cmd.dec_load = 1'b1;
         CS_SW_XX:  cmd.mul_sel = MUL_XX;
         CS_SW_YY: begin
            cmd.tmp_load = 1'b1;
            cmd.mul_sel  = MUL_YY;
         end
         CS_SW_B2T: begin
            cmd.tmp_load = 1'b1;
            cmd.mul_sel  = MUL_B2T;
         end
         CS_SW_A2T: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_A2T;
         end
         CS_SW_A2B2: begin
            cmd.acc_op  = ACC_ADD4;
            cmd.mul_sel = MUL_A2B2;
         end
         CS_SW_SUB: cmd.acc_op = ACC_SUB4R;
         CS_SW_DIV: begin
            cmd.dec_load = 1'b1;
            cmd.set_r2   = 1'b1;
         end
         CS_STEP:   cmd.step = 1'b1;
         CS_EMIT:   cmd.emit_load = status.out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- design/mer_datapath.sv -----
// ----------------------------------------------------------------------------
// mer_datapath
// Ellipse state, shared multiplier, accumulator, midpoint step and the
// output word register.
// ----------------------------------------------------------------------------
module mer_datapath
   import mer_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [COORD_BITS-1:0]   req_center_x,
   input  logic [COORD_BITS-1:0]   req_center_y,
   input  logic [COORD_BITS-1:0]   req_radius_a,
   input  logic [COORD_BITS-1:0]   req_radius_b,
   input  mer_cmd_type             cmd,
   output mer_status_type          status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [PIX_W-1:0] rsp_pixel_x,
   output logic signed [PIX_W-1:0] rsp_pixel_y,
   output logic                    rsp_last_of_item,
   output logic                    rsp_ellipse_done
);

   localparam logic [DEC_W-1:0] DEC_TWO   = DEC_W'(2);
   localparam logic [DEC_W-1:0] DEC_THREE = DEC_W'(3);

   // saved parameters
   logic [COORD_BITS-1:0] center_x_ff, center_y_ff, radius_a_ff, radius_b_ff;

   // run state
   logic                      active_ff, active_in;
   logic                      r2_ff, r2_in;
   logic                      done_ff, done_in;
   logic signed [STEP_W-1:0]  step_x_ff, step_x_in;
   logic signed [STEP_W-1:0]  step_y_ff, step_y_in;
   logic signed [SLOPE_W-1:0] slope_x_ff, slope_x_in;
   logic signed [SLOPE_W-1:0] slope_y_ff, slope_y_in;
   logic [DEC_W-1:0]          decision_ff, decision_in;

   // arithmetic
   logic [SQ_W-1:0]   a2_ff, b2_ff;
   logic [MUL_W-1:0]  tmp_ff;
   logic [MUL_W-1:0]  op_a, op_b;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DEC_W-1:0]  acc_ff, acc_in;
   logic [DEC_W-1:0]  acc_biased, dec_div;
   logic [DEC_W-1:0]  prod_x4, a2_ext, b2_ext;
   logic [STEP_W-1:0] y_minus_one;

   // step
   logic signed [SLOPE_W-1:0] two_a2, two_b2, sx_inc, sy_dec;
   logic signed [STEP_W-1:0]  x_stp, y_stp;
   logic signed [SLOPE_W-1:0] sx_stp, sy_stp;
   logic [DEC_W-1:0]          dec_stp;
   logic                      dec_neg, dec_pos;

   // output word
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_W-1:0] pix_x_ff, pix_y_ff;
   logic                    last_ff, edone_ff;
   logic [PIX_SUM_W-1:0]    px_sum, py_sum;

   // ---------------- multiplier ----------------
   assign y_minus_one = step_y_ff - STEP_W'(1);

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_sel)
         MUL_AA: begin
            op_a = MUL_W'(radius_a_ff);
            op_b = MUL_W'(radius_a_ff);
         end
         MUL_BB: begin
            op_a = MUL_W'(radius_b_ff);
            op_b = MUL_W'(radius_b_ff);
         end
         MUL_A2B: begin
            op_a = MUL_W'(a2_ff);
            op_b = MUL_W'(radius_b_ff);
         end
         MUL_XX: begin
            op_a = MUL_W'({step_x_ff, 1'b1});
            op_b = MUL_W'({step_x_ff, 1'b1});
         end
         MUL_YY: begin
            op_a = MUL_W'(y_minus_one);
            op_b = MUL_W'(y_minus_one);
         end
         MUL_B2T: begin
            op_a = MUL_W'(b2_ff);
            op_b = tmp_ff;
         end
         MUL_A2T: begin
            op_a = MUL_W'(a2_ff);
            op_b = tmp_ff;
         end
         MUL_A2B2: begin
            op_a = MUL_W'(a2_ff);
            op_b = MUL_W'(b2_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   // ---------------- accumulator (quarter units) ----------------
   assign prod_x4 = {prod_ff[DEC_W-3:0], 2'b00};
   assign a2_ext  = DEC_W'(a2_ff);
   assign b2_ext  = DEC_W'(b2_ff);

   always_comb begin
      case (cmd.acc_op)
         ACC_HOLD:  acc_in = acc_ff;
         ACC_LOAD:  acc_in = prod_ff;
         ACC_ADD4:  acc_in = acc_ff + prod_x4;
         ACC_SUB4R: acc_in = acc_ff - prod_x4 + DEC_TWO;
         ACC_INIT:  acc_in = {b2_ext[DEC_W-3:0], 2'b00} - prod_x4 + a2_ext + DEC_TWO;
         default:   acc_in = acc_ff;
      endcase
   end

   // divide by four, rounding toward zero
   assign acc_biased = acc_ff + (acc_ff[DEC_W-1] ? DEC_THREE : '0);
   assign dec_div    = {{2{acc_biased[DEC_W-1]}}, acc_biased[DEC_W-1:2]};

   // ---------------- midpoint step ----------------
   assign two_a2  = SLOPE_W'({a2_ff, 1'b0});
   assign two_b2  = SLOPE_W'({b2_ff, 1'b0});
   assign sx_inc  = slope_x_ff + two_b2;
   assign sy_dec  = slope_y_ff - two_a2;
   assign dec_neg = decision_ff[DEC_W-1];
   assign dec_pos = !dec_neg && (decision_ff != '0);

   always_comb begin
      x_stp   = step_x_ff;
      y_stp   = step_y_ff;
      sx_stp  = slope_x_ff;
      sy_stp  = slope_y_ff;
      dec_stp = decision_ff;
      if (!r2_ff) begin
         x_stp  = step_x_ff + STEP_W'(1);
         sx_stp = sx_inc;
         if (dec_neg) begin
            dec_stp = decision_ff + b2_ext + DEC_W'(sx_inc);
         end else begin
            y_stp   = step_y_ff - STEP_W'(1);
            sy_stp  = sy_dec;
            dec_stp = decision_ff + b2_ext + DEC_W'(sx_inc) - DEC_W'(sy_dec);
         end
      end else begin
         y_stp  = step_y_ff - STEP_W'(1);
         sy_stp = sy_dec;
         if (dec_pos) begin
            dec_stp = decision_ff + a2_ext - DEC_W'(sy_dec);
         end else begin
            x_stp   = step_x_ff + STEP_W'(1);
            sx_stp  = sx_inc;
            dec_stp = decision_ff + a2_ext - DEC_W'(sy_dec) + DEC_W'(sx_inc);
         end
      end
   end

   // ---------------- run state next values ----------------
   always_comb begin
      active_in   = active_ff;
      r2_in       = r2_ff;
      done_in     = done_ff;
      step_x_in   = step_x_ff;
      step_y_in   = step_y_ff;
      slope_x_in  = slope_x_ff;
      slope_y_in  = slope_y_ff;
      decision_in = decision_ff;
      if (cmd.init_run) begin
         active_in  = (radius_b_ff != '0);
         done_in    = (radius_b_ff == '0);
         r2_in      = 1'b0;
         step_x_in  = '0;
         step_y_in  = STEP_W'(radius_b_ff);
         slope_x_in = '0;
         slope_y_in = {prod_ff[SLOPE_W-2:0], 1'b0};
      end
      if (cmd.set_r2) begin
         r2_in = 1'b1;
      end
      if (cmd.dec_load) begin
         decision_in = dec_div;
      end
      if (cmd.step) begin
         step_x_in   = x_stp;
         step_y_in   = y_stp;
         slope_x_in  = sx_stp;
         slope_y_in  = sy_stp;
         decision_in = dec_stp;
         done_in     = y_stp[STEP_W-1] || (y_stp == '0);
         active_in   = !(y_stp[STEP_W-1] || (y_stp == '0));
      end
   end

   // ---------------- output word ----------------
   assign px_sum = cmd.point_idx[0] ?
                   PIX_SUM_W'(center_x_ff) - PIX_SUM_W'(step_x_ff) :
                   PIX_SUM_W'(center_x_ff) + PIX_SUM_W'(step_x_ff);
   assign py_sum = cmd.point_idx[1] ?
                   PIX_SUM_W'(center_y_ff) - PIX_SUM_W'(step_y_ff) :
                   PIX_SUM_W'(center_y_ff) + PIX_SUM_W'(step_y_ff);

   always_comb begin
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         r2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         r2_ff        <= r2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      done_ff     <= done_in;
      step_x_ff   <= step_x_in;
      step_y_ff   <= step_y_in;
      slope_x_ff  <= slope_x_in;
      slope_y_ff  <= slope_y_in;
      decision_ff <= decision_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      if (cmd.load_params) begin
         center_x_ff <= req_center_x;
         center_y_ff <= req_center_y;
         radius_a_ff <= req_radius_a;
         radius_b_ff <= req_radius_b;
      end
      if (cmd.a2_load) begin
         a2_ff <= prod_ff[SQ_W-1:0];
      end
      if (cmd.b2_load) begin
         b2_ff <= prod_ff[SQ_W-1:0];
      end
      if (cmd.tmp_load) begin
         tmp_ff <= prod_ff[MUL_W-1:0];
      end
      if (cmd.emit_load) begin
         pix_x_ff <= px_sum[PIX_W-1:0];
         pix_y_ff <= py_sum[PIX_W-1:0];
         last_ff  <= (cmd.point_idx == LAST_POINT);
         edone_ff <= (cmd.point_idx == LAST_POINT) && done_ff;
      end
   end

   assign status.active      = active_ff;
   assign status.need_switch = !r2_ff && !(slope_x_ff < slope_y_ff);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = pix_x_ff;
   assign rsp_pixel_y      = pix_y_ff;
   assign rsp_last_of_item = last_ff;
   assign rsp_ellipse_done = edone_ff;

endmodule

// ----- design/midpoint_ellipse_rasterizer.sv -----
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse point generator, one step per advance word.
// ----------------------------------------------------------------------------
// A start word (func 0) latches center and radii, sets up region one and
// returns the four symmetric points (xc+x,yc+y), (xc-x,yc+y), (xc+x,yc-y),
// (xc-x,yc-y); each advance word (func 1) does one midpoint step and returns
// four more, duplicates kept. The fourth word of each item has last_of_item
// set, and the fourth word of the final step also has ellipse_done. A start
// with radius_b zero finishes at once. Advance words while no ellipse runs
// are taken and return nothing. A start while running abandons the old run.
// Flow: one word at a time. An ordinary advance is taken and stepped in
// the same cycle, then its four points leave through a single output
// register, one per cycle while rsp_ready is high. A start computes a^2,
// b^2 and a^2*b on the shared 24x24 multiplier, then the decision setup
// and divide by four. In the advance that crosses into region two, five
// products on the same multiplier build the new decision value before
// the step. A new word is taken while the last point of the previous one
// still sits in the output register. Output stalls hold the sequencer in
// its emit state.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer
   import mer_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_func,
   input  logic [COORD_BITS-1:0]   req_center_x,
   input  logic [COORD_BITS-1:0]   req_center_y,
   input  logic [COORD_BITS-1:0]   req_radius_a,
   input  logic [COORD_BITS-1:0]   req_radius_b,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [PIX_W-1:0] rsp_pixel_x,
   output logic signed [PIX_W-1:0] rsp_pixel_y,
   output logic                    rsp_last_of_item,
   output logic                    rsp_ellipse_done
);

   mer_cmd_type    cmd;
   mer_status_type status;

   // sequencer: owns req_ready and the point index
   mer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // ellipse state, multiplier, step logic and output word register
   mer_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius_a     (req_radius_a),
      .req_radius_b     (req_radius_b),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_ellipse_done (rsp_ellipse_done)
   );

   // a waiting word is never overwritten
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> status.out_free)
      else $error("point loaded while output word still pending");

   // no step without a running ellipse
   a_step_active: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> status.active)
      else $error("midpoint step issued with no ellipse running");

   // an advance with nothing running returns straight to idle
   a_idle_advance: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_func == FUNC_ADVANCE) && !status.active)
      |=> req_ready)
      else $error("advance while idle did not return to idle");

   // the done flag only rides on the fourth word of an item
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ellipse_done) |-> rsp_last_of_item)
      else $error("ellipse_done on a word that is not last of its item");

endmodule

// ----- dv/midpoint_ellipse_rasterizer_tb.sv -----
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_tb
// Self-checking bench for the midpoint ellipse point generator.
// ----------------------------------------------------------------------------
// A software copy of the ellipse stepper runs beside the block. Each accepted
// request word updates it and queues the four points that word must return.
// Every returned point is checked field by field against the oldest queued
// one. The stimulus has a short directed part (field extremes, idle advance,
// restart mid-run, zero radii, region switch), a back-pressure part, and a
// random part made mostly of complete runs on small ellipses. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_tb
   import mer_pkg::*;
();

   localparam int RANDOM_ITEMS     = 170;
   localparam int LONG_HOLD_CYCLES = 300;   // receiver hold-off, long enough to fill the block
   localparam int WATCHDOG_LIMIT   = 2000;  // cycles with no word moving on either side
   localparam int LINGER_CYCLES    = 40;    // after the last point, longer than any item

   // one returned point as the block should present it
   typedef struct packed {
      logic signed [PIX_W-1:0] pixel_x;
      logic signed [PIX_W-1:0] pixel_y;
      logic                    last_of_item;
      logic                    ellipse_done;
   } ellipse_point_type;

   // ---------------------------------------------------------------------
   // clock, reset and block ports
   // ---------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_func = FUNC_START;
   logic [COORD_BITS-1:0]   req_center_x = '0;
   logic [COORD_BITS-1:0]   req_center_y = '0;
   logic [COORD_BITS-1:0]   req_radius_a = '0;
   logic [COORD_BITS-1:0]   req_radius_b = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [PIX_W-1:0] rsp_pixel_x;
   logic signed [PIX_W-1:0] rsp_pixel_y;
   logic                    rsp_last_of_item;
   logic                    rsp_ellipse_done;

   always #4 clock = ~clock;

   midpoint_ellipse_rasterizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius_a     (req_radius_a),
      .req_radius_b     (req_radius_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_ellipse_done (rsp_ellipse_done)
   );

   // ---------------------------------------------------------------------
   // stepper shadow state
   // Steps and slopes are kept as 64-bit signed; the decision value is a
   // plain 64-bit pattern so that it wraps exactly like the block's
   // two's complement accumulator (no wrap occurs at these widths).
   // ---------------------------------------------------------------------
   bit                    ell_running;
   bit                    ell_region_two;
   longint                pos_x, pos_y;       // current x / y offset
   longint                slope_x, slope_y;   // fx = 2b^2x, fy = 2a^2y
   bit [63:0]             decision;
   logic [COORD_BITS-1:0] cen_x, cen_y, rad_a, rad_b;

   ellipse_point_type points_due[$];   // points still owed by the block, oldest first
   ellipse_point_type point_head;
   int unsigned       mismatches;
   int unsigned       plotted_items;   // request words that produced points

   // idling controls, flipped by the tests
   bit          send_gaps_on  = 1'b1;
   bit          ready_gaps_on = 1'b1;
   logic        long_hold_asked = 1'b0;
   logic        long_hold_done  = 1'b0;
   int unsigned ready_wait;
   int unsigned quiet_cycles;

   // mostly back to back, sometimes a few cycles, now and then a long gap
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      else if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic logic [COORD_BITS-1:0] any_coord();
      return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
   endfunction

   // truncating divide by four of a two's complement 64-bit value
   function automatic bit [63:0] quarter_trunc(bit [63:0] v);
      if (v[63]) return 64'd0 - ((64'd0 - v) >> 2);
      return v >> 2;
   endfunction

   // queue the four mirrored points of the current offset
   function automatic void queue_points(bit finished);
      longint            cx_l, cy_l, px, py;
      ellipse_point_type pt;
      cx_l = cen_x;
      cy_l = cen_y;
      for (int k = 0; k < 4; k++) begin
         // bit 0 of the index mirrors x, bit 1 mirrors y
         px = k[0] ? cx_l - pos_x : cx_l + pos_x;
         py = k[1] ? cy_l - pos_y : cy_l + pos_y;
         pt.pixel_x      = px[PIX_W-1:0];
         pt.pixel_y      = py[PIX_W-1:0];
         pt.last_of_item = (k == LAST_POINT);
         pt.ellipse_done = (k == LAST_POINT) && finished;
         points_due.push_back(pt);
      end
   endfunction

   // Apply one request word to the shadow stepper. Returns 1 when the word
   // produces points, 0 for an advance with no ellipse running.
   function automatic bit plot_item(logic func, logic [COORD_BITS-1:0] cx,
                                    logic [COORD_BITS-1:0] cy,
                                    logic [COORD_BITS-1:0] ra,
                                    logic [COORD_BITS-1:0] rb);
      bit [63:0] ea, eb, a2, b2, xx, ym, q;
      bit        finished;
      if (func == FUNC_START) begin
         cen_x = cx;
         cen_y = cy;
         rad_a = ra;
         rad_b = rb;
         ea = rad_a;
         eb = rad_b;
         a2 = ea * ea;
         b2 = eb * eb;
         pos_x   = 0;
         pos_y   = eb;
         slope_x = 0;
         slope_y = 2 * a2 * eb;
         // region one start value in quarter units, +2 rounds to nearest when q + 2 is not negative
         q = 4 * b2 - 4 * a2 * eb + a2;
         decision = quarter_trunc(q + 2);
         ell_region_two = 1'b0;
         finished    = (rad_b == 0);   // flat ellipse: done on the start word
         ell_running = !finished;
         queue_points(finished);
         return 1'b1;
      end

      if (!ell_running) return 1'b0;

      ea = rad_a;
      eb = rad_b;
      a2 = ea * ea;
      b2 = eb * eb;

      // first step that finds fx >= fy switches over and steps in region two
      if (!ell_region_two && !(slope_x < slope_y)) begin
         xx = 2 * pos_x + 1;
         ym = pos_y - 1;
         q  = b2 * xx * xx + 4 * a2 * ym * ym - 4 * a2 * b2;
         decision = quarter_trunc(q + 2);
         ell_region_two = 1'b1;
      end

      if (!ell_region_two) begin
         pos_x++;
         slope_x += 2 * b2;
         if (decision[63]) begin
            decision += b2 + slope_x;
         end else begin
            pos_y--;
            slope_y -= 2 * a2;
            decision += b2 + slope_x - slope_y;
         end
      end else begin
         pos_y--;
         slope_y -= 2 * a2;
         if (!decision[63] && decision != 0) begin
            decision += a2 - slope_y;
         end else begin
            pos_x++;
            slope_x += 2 * b2;
            decision += a2 - slope_y + slope_x;
         end
      end

      finished = (pos_y <= 0);
      if (finished) ell_running = 1'b0;
      queue_points(finished);
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // Called at a clock edge; returns at the edge where the word is taken.
   // ---------------------------------------------------------------------
   task automatic send_word(logic func, logic [COORD_BITS-1:0] cx,
                            logic [COORD_BITS-1:0] cy,
                            logic [COORD_BITS-1:0] ra,
                            logic [COORD_BITS-1:0] rb);
      int unsigned gap;
      gap = send_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_center_x <= cx;
      req_center_y <= cy;
      req_radius_a <= ra;
      req_radius_b <= rb;
      do @(posedge clock); while (!req_ready);
      if (plot_item(func, cx, cy, ra, rb)) plotted_items++;
   endtask

   task automatic send_start(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                             logic [COORD_BITS-1:0] ra, logic [COORD_BITS-1:0] rb);
      send_word(FUNC_START, cx, cy, ra, rb);
   endtask

   // advance words carry random payload, which the block must ignore
   task automatic send_advance();
      send_word(FUNC_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord());
   endtask

   // step the running ellipse until it finishes or max_steps words are sent
   task automatic run_until_done(int unsigned max_steps);
      int unsigned k;
      k = 0;
      while (ell_running && k < max_steps) begin
         send_advance();
         k++;
      end
   endtask

   // drop valid and hold off until every owed point has come back;
   // always waits on the clock before it checks, so valid is not driven twice in a step
   task automatic settle_outputs();
      req_valid <= 1'b0;
      do @(posedge clock); while (points_due.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // response side: random stalls, plus one long hold-off when asked
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (ready_wait != 0) begin
         ready_wait <= ready_wait - 1;
         rsp_ready  <= 1'b0;
      end else if (long_hold_asked && !long_hold_done) begin
         long_hold_done <= 1'b1;
         ready_wait     <= LONG_HOLD_CYCLES;
         rsp_ready      <= 1'b0;
      end else if (ready_gaps_on && $urandom_range(0, 2) == 0) begin
         ready_wait <= pick_gap();
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each taken point with the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (points_due.size() == 0) begin
            $display("%0t: point with none owed, expected nothing, got x=%0d y=%0d",
                     $time, rsp_pixel_x, rsp_pixel_y);
            mismatches++;
         end else begin
            point_head = points_due.pop_front();
            if (rsp_pixel_x !== point_head.pixel_x) begin
               $display("%0t: pixel_x expected %0d, got %0d",
                        $time, point_head.pixel_x, rsp_pixel_x);
               mismatches++;
            end
            if (rsp_pixel_y !== point_head.pixel_y) begin
               $display("%0t: pixel_y expected %0d, got %0d",
                        $time, point_head.pixel_y, rsp_pixel_y);
               mismatches++;
            end
            if (rsp_last_of_item !== point_head.last_of_item) begin
               $display("%0t: last_of_item expected %0b, got %0b",
                        $time, point_head.last_of_item, rsp_last_of_item);
               mismatches++;
            end
            if (rsp_ellipse_done !== point_head.ellipse_done) begin
               $display("%0t: ellipse_done expected %0b, got %0b",
                        $time, point_head.ellipse_done, rsp_ellipse_done);
               mismatches++;
            end
         end
      end
   end

   // hang detector: nothing moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // advance straight after reset: taken, no points
   task automatic test_advance_while_idle();
      send_advance();
   endtask

   // centers and radii at both ends of their range; negative pixels come
   // out of the center-zero case
   task automatic test_field_extremes();
      send_start('0, '1, '1, '1);
      run_until_done(2);
      send_start('1, '0, '1, '1);   // also abandons the running ellipse
      run_until_done(1);
      send_start('1, '1, 10'd1, 10'd1);
      run_until_done(1000);
   endtask

   // new start mid-run, then a small ellipse that crosses into region two
   task automatic test_restart_mid_run();
      send_start(10'd512, 10'd300, 10'd9, 10'd6);
      run_until_done(2);
      send_start(10'd100, 10'd900, 10'd2, 10'd3);
      run_until_done(1000);
   endtask

   // b = 0 finishes on the start word; the next advance returns nothing
   task automatic test_zero_radius_b();
      send_start(10'd300, 10'd700, '1, 10'd0);
      send_advance();
   endtask

   // a = 0 skips region one and walks y down to zero
   task automatic test_zero_radius_a();
      send_start(10'd40, 10'd20, 10'd0, 10'd3);
      run_until_done(1000);
      send_advance();
   endtask

   // receiver holds off while the sender keeps pushing, so the block backs
   // up and stalls its input; then the sender waits for a full drain
   task automatic test_output_backpressure();
      send_gaps_on    = 1'b0;
      long_hold_asked <= 1'b1;
      send_start(10'd512, 10'd512, 10'd12, 10'd7);
      run_until_done(10);
      settle_outputs();
      run_until_done(1000);
      settle_outputs();
      send_gaps_on = 1'b1;
   endtask

   // mostly complete runs on small ellipses, some huge ones cut short,
   // some abandoned early, plus stray words of either kind
   task automatic test_random_runs();
      int unsigned goal, roll;
      logic [COORD_BITS-1:0] ra, rb;
      goal = plotted_items + RANDOM_ITEMS;
      while (plotted_items < goal) begin
         roll = $urandom_range(0, 99);
         // on each side, about a quarter of the stretches run with no idling at all
         send_gaps_on  = ($urandom_range(0, 3) != 0);
         ready_gaps_on = ($urandom_range(0, 3) != 0);
         if (roll < 15) begin
            if ($urandom_range(0, 1) == 0) send_advance();
            else send_start(any_coord(), any_coord(), any_coord(), any_coord());
         end else if (roll < 22) begin
            send_start(any_coord(), any_coord(), any_coord(), any_coord());
            run_until_done($urandom_range(0, 12));
         end else begin
            ra = COORD_BITS'($urandom_range(0, 20));
            rb = COORD_BITS'($urandom_range(0, 20));
            send_start(any_coord(), any_coord(), ra, rb);
            run_until_done(roll < 32 ? $urandom_range(0, 10) : 1000);
            if ($urandom_range(0, 3) == 0) send_advance();   // past the end
         end
      end
      ready_gaps_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_advance_while_idle();
      test_field_extremes();
      test_restart_mid_run();
      test_zero_radius_b();
      test_zero_radius_a();
      test_output_backpressure();
      test_random_runs();

      settle_outputs();
      repeat (LINGER_CYCLES) @(posedge clock);
      if (mismatches == 0 && points_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/mer_pkg.sv
design/mer_ctrl.sv
design/mer_datapath.sv
design/midpoint_ellipse_rasterizer.sv
dv/midpoint_ellipse_rasterizer_tb.sv
